FILE: design/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants of the 3x3 pixel filter
// Frame geometry, beat layouts, configuration block and job format passed
// from the window front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // Frame geometry
    localparam int WIDTH  = 256;
    localparam int HEIGHT = 256;
    localparam int COL_W  = $clog2(WIDTH);
    // rows run to HEIGHT+1 during the flush phase
    localparam int ROW_W  = $clog2(HEIGHT + 2);

    // Datapath widths
    localparam int PIX_W  = 8;
    localparam int COEF_W = 8;
    localparam int PROD_W = PIX_W + COEF_W + 1;
    // nine products of 255 * 128 at most: 293760 < 2**19, plus sign
    localparam int SUM_W  = 20;
    localparam int MAG_W  = SUM_W - 1;
    localparam int DIV_W  = 12;
    localparam int STEP_W = $clog2(MAG_W + 1);
    localparam int LINE_W = 2 * PIX_W;

    localparam int OFFSET  = 128;
    localparam int PIX_MAX = 255;

    // Job queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int REG_COUNT = 5;
    localparam int ADDR_W    = $clog2(4 * REG_COUNT);
    localparam int DATA_W    = 32;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [ADDR_W-3:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MIDDLE = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_DIVISOR       = 3'd3,
        REG_ADD_OFFSET    = 3'd4
    } reg_index_t;

    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic [2:0][COEF_W-1:0]    kernel_row_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [SUM_W:0]     wide_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [DIV_W-1:0]          dmag_t;
    typedef logic [STEP_W-1:0]         step_t;
    typedef logic [QPTR_W-1:0]         qptr_t;
    typedef logic [QCNT_W-1:0]         qcnt_t;

    typedef struct packed {
        logic operation;
        pix_t pixel_in;
    } item_t;

    typedef struct packed {
        pix_t pixel_out;
        logic last_of_frame;
    } result_t;

    typedef struct packed {
        kernel_row_t             kernel_row_top;
        kernel_row_t             kernel_row_middle;
        kernel_row_t             kernel_row_bottom;
        logic signed [DIV_W-1:0] divisor;
        logic                    add_offset;
    } cfg_t;

    // one line store word: row two above and row one above the incoming one
    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_word_t;

    // masked 3x3 window, entry i*3+j is kernel row i, column j
    typedef struct packed {
        pix_t [8:0] win;
        logic       last;
    } job_t;

endpackage

FILE: design/conv3x3_pixel_filter_top.sv
// ----------------------------------------------------------------------------
// conv3x3_pixel_filter_top: 3x3 convolution filter for 8-bit grey frames
// Register block, window front end, job queue and arithmetic back end.
// ----------------------------------------------------------------------------
// Usage:
//   Send the frame's pixels in raster order as item beats (operation = pixel),
//   then WIDTH+1 flush beats to drain the last line. Each beat after the
//   first WIDTH+1 yields one result beat for the next output position in
//   raster order; last_of_frame marks the bottom right pixel, after which the
//   next beat starts a new frame.
//   Program the kernel rows, divisor and offset through the APB port while
//   the block is idle; pready is always high and a write lands at the access
//   phase.
//   A result beat is registered in the front end, passes the job queue,
//   takes one multiply-accumulate step per kernel row, a bit-serial
//   division when the divisor is nonzero and the clamp into the output
//   register. The back end ends each result before taking the next job;
//   beats without a result pass at one per cycle while item_ready is high.
//   Reset clears the position counters, the window and all handshakes; the
//   line stores are not cleared, their stale rows are masked out.
//   A stalled receiver fills the four-entry job queue, then item_ready drops.
// ----------------------------------------------------------------------------
module conv3x3_pixel_filter_top (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           item_valid,
    output logic                           item_ready,
    input  cpf_pkg::item_t                 item,

    output logic                           result_valid,
    input  logic                           result_ready,
    output cpf_pkg::result_t               result,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpf_pkg::ADDR_W-1:0]     paddr,
    input  logic [cpf_pkg::DATA_W-1:0]     pwdata,
    output logic [cpf_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    cpf_pkg::cfg_t      cfg_reg, cfg_next;
    cpf_pkg::reg_index_t reg_index;
    logic               cfg_write;

    cpf_pkg::qcnt_t     queue_count;
    logic               job_push;
    cpf_pkg::job_t      job_in;
    logic               job_pop;
    cpf_pkg::job_t      job_out;

    // Register block: word addresses, byte lanes ignored
    assign pready    = 1'b1;
    assign reg_index = cpf_pkg::reg_index_t'(paddr[cpf_pkg::ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                cpf_pkg::REG_KERNEL_TOP:
                    cfg_next.kernel_row_top    = pwdata[23:0];
                cpf_pkg::REG_KERNEL_MIDDLE:
                    cfg_next.kernel_row_middle = pwdata[23:0];
                cpf_pkg::REG_KERNEL_BOTTOM:
                    cfg_next.kernel_row_bottom = pwdata[23:0];
                cpf_pkg::REG_DIVISOR:
                    cfg_next.divisor           = pwdata[cpf_pkg::DIV_W-1:0];
                cpf_pkg::REG_ADD_OFFSET:
                    cfg_next.add_offset        = pwdata[0];
                default:
                    cfg_next = cfg_reg;   // drop writes past the register list
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            cpf_pkg::REG_KERNEL_TOP:
                prdata = cpf_pkg::DATA_W'(cfg_reg.kernel_row_top);
            cpf_pkg::REG_KERNEL_MIDDLE:
                prdata = cpf_pkg::DATA_W'(cfg_reg.kernel_row_middle);
            cpf_pkg::REG_KERNEL_BOTTOM:
                prdata = cpf_pkg::DATA_W'(cfg_reg.kernel_row_bottom);
            cpf_pkg::REG_DIVISOR:
                prdata = cpf_pkg::DATA_W'(unsigned'(cfg_reg.divisor));
            cpf_pkg::REG_ADD_OFFSET:
                prdata = cpf_pkg::DATA_W'(cfg_reg.add_offset);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: track the raster position, age the line stores, build windows
    cpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .queue_count (queue_count),
        .job_push    (job_push),
        .job         (job_in)
    );

    // Hold finished windows so the arithmetic can stall on its own
    cpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .count     (queue_count)
    );

    // Back end: accumulate, divide, offset, clamp, register the result beat
    cpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_avail    (queue_count != '0),
        .job          (job_out),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: design/cpf_ram.sv
// ----------------------------------------------------------------------------
// cpf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/cpf_front.sv
// ----------------------------------------------------------------------------
// cpf_front: raster tracking, line stores and window assembly
// Accepts pixel and flush beats, keeps the two line stores and the 3x3
// window, and pushes one masked window job per output position.
// ----------------------------------------------------------------------------
module cpf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  cpf_pkg::item_t      item,
    input  cpf_pkg::qcnt_t      queue_count,
    output logic                job_push,
    output cpf_pkg::job_t       job
);

    cpf_pkg::col_t          col_reg, col_next;
    cpf_pkg::row_t          row_reg, row_next;
    logic                   b_valid_reg;
    cpf_pkg::col_t          b_col_reg;
    cpf_pkg::row_t          b_row_reg;
    cpf_pkg::pix_t          b_cur_reg;
    cpf_pkg::pix_t [8:0]    win_reg, win_next;

    logic                   accept;
    cpf_pkg::pix_t          cur;
    cpf_pkg::line_word_t    rd_word;
    cpf_pkg::line_word_t    wr_word;

    logic                   col_zero;
    logic                   top_out, bottom_out, left_out, right_out;
    logic                   has_result;
    logic [2:0]             row_ok, col_ok;

    // hold off while the queue could not take the beat in flight plus this one
    assign item_ready = (queue_count + cpf_pkg::qcnt_t'(b_valid_reg))
                        < cpf_pkg::qcnt_t'(cpf_pkg::QUEUE_DEPTH);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        cur = '0;
        if (item.operation == cpf_pkg::OP_PIXEL
            && row_reg < cpf_pkg::row_t'(cpf_pkg::HEIGHT))
        begin
            cur = item.pixel_in;
        end

        if (row_reg == cpf_pkg::row_t'(cpf_pkg::HEIGHT + 1) && col_reg == '0)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_reg == cpf_pkg::col_t'(cpf_pkg::WIDTH - 1))
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    cpf_ram #(
        .DATA_W (cpf_pkg::LINE_W),
        .DEPTH  (cpf_pkg::WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_col_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_word)
    );

    // age the lines: lower moves up, the current pixel becomes lower
    assign wr_word.upper = rd_word.lower;
    assign wr_word.lower = b_cur_reg;

    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_word.upper;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_word.lower;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = b_cur_reg;
    end

    // Output position trails the input by one line and one pixel; at
    // column zero it is the right edge of the line before.
    assign col_zero   = (b_col_reg == '0);
    assign top_out    = col_zero ? (b_row_reg == cpf_pkg::row_t'(2))
                                 : (b_row_reg == cpf_pkg::row_t'(1));
    assign bottom_out = col_zero ? (b_row_reg == cpf_pkg::row_t'(cpf_pkg::HEIGHT + 1))
                                 : (b_row_reg == cpf_pkg::row_t'(cpf_pkg::HEIGHT));
    assign left_out   = (b_col_reg == cpf_pkg::col_t'(1));
    assign right_out  = col_zero;
    assign has_result = (b_row_reg >= cpf_pkg::row_t'(2))
                        || (b_row_reg == cpf_pkg::row_t'(1) && !col_zero);

    assign row_ok = {!bottom_out, 1'b1, !top_out};
    assign col_ok = {!right_out, 1'b1, !left_out};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                job.win[i*3+j] = (row_ok[i] && col_ok[j]) ? win_next[i*3+j] : '0;
            end
        end
        job.last = bottom_out && right_out;
    end

    assign job_push = b_valid_reg && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (b_valid_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg <= col_reg;
            b_row_reg <= row_reg;
            b_cur_reg <= cur;
        end
    end

endmodule

FILE: design/cpf_queue.sv
// ----------------------------------------------------------------------------
// cpf_queue: short job queue between front and back end
// First-in first-out store of window jobs with an occupancy count.
// ----------------------------------------------------------------------------
module cpf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpf_pkg::job_t   push_data,
    input  logic            pop,
    output cpf_pkg::job_t   pop_data,
    output cpf_pkg::qcnt_t  count
);

    cpf_pkg::job_t  mem_reg [cpf_pkg::QUEUE_DEPTH];
    cpf_pkg::qptr_t wptr_reg, wptr_next;
    cpf_pkg::qptr_t rptr_reg, rptr_next;
    cpf_pkg::qcnt_t count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == cpf_pkg::qptr_t'(cpf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == cpf_pkg::qptr_t'(cpf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rptr_reg];
    assign count    = count_reg;

endmodule

FILE: design/cpf_back.sv
// ----------------------------------------------------------------------------
// cpf_back: multiply-accumulate, division and clamping of window jobs
// One kernel row per cycle, then an optional bit-serial signed division,
// offset and clamp into the output register.
// ----------------------------------------------------------------------------
module cpf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cpf_pkg::cfg_t     cfg,
    input  logic              job_avail,
    input  cpf_pkg::job_t     job,
    output logic              job_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output cpf_pkg::result_t  result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    cpf_pkg::step_t             step_reg, step_next;
    cpf_pkg::pix_t [8:0]        win_reg, win_next;
    cpf_pkg::kernel_row_t [2:0] kern_reg, kern_next;
    logic                       last_reg, last_next;
    cpf_pkg::sum_t              acc_reg, acc_next;
    cpf_pkg::sum_t              val_reg, val_next;
    cpf_pkg::mag_t              dvd_reg, dvd_next;
    cpf_pkg::dmag_t             rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    cpf_pkg::result_t           result_reg;
    logic                       result_valid_reg, result_valid_next;

    cpf_pkg::prod_t [2:0]       prod;
    cpf_pkg::sum_t              mac_sum;
    cpf_pkg::mag_t              mac_mag;
    cpf_pkg::dmag_t             dmag;
    logic [cpf_pkg::DIV_W:0]    rem_shift;
    logic [cpf_pkg::DIV_W:0]    rem_sub;
    logic                       ge;
    cpf_pkg::mag_t              quot;
    cpf_pkg::wide_t             biased;
    cpf_pkg::pix_t              clamped;
    logic                       load;

    // top kernel row against top window row; rows shift up each step
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            prod[j] = $signed({1'b0, win_reg[j]}) * $signed(kern_reg[0][j]);
        end
        mac_sum = acc_reg + cpf_pkg::sum_t'(prod[0]) + cpf_pkg::sum_t'(prod[1])
                  + cpf_pkg::sum_t'(prod[2]);
        mac_mag = mac_sum[cpf_pkg::SUM_W-1] ? cpf_pkg::mag_t'(-mac_sum)
                                             : cpf_pkg::mag_t'(mac_sum);
    end

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        dmag      = cfg.divisor[cpf_pkg::DIV_W-1] ? cpf_pkg::dmag_t'(~cfg.divisor + 1'b1)
                                                   : cpf_pkg::dmag_t'(cfg.divisor);
        rem_shift = {rem_reg, dvd_reg[cpf_pkg::MAG_W-1]};
        rem_sub   = rem_shift - {1'b0, dmag};
        ge        = rem_shift >= {1'b0, dmag};
        quot      = {dvd_reg[cpf_pkg::MAG_W-2:0], ge};
    end

    always_comb
    begin
        biased = cpf_pkg::wide_t'(val_reg)
                 + (cfg.add_offset ? cpf_pkg::wide_t'(cpf_pkg::OFFSET) : cpf_pkg::wide_t'(0));
        if (biased < cpf_pkg::wide_t'(0))
        begin
            clamped = '0;
        end
        else if (biased > cpf_pkg::wide_t'(cpf_pkg::PIX_MAX))
        begin
            clamped = cpf_pkg::pix_t'(cpf_pkg::PIX_MAX);
        end
        else
        begin
            clamped = biased[cpf_pkg::PIX_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        win_next   = win_reg;
        kern_next  = kern_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;
        val_next   = val_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        job_pop    = 1'b0;
        load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop    = 1'b1;
                    win_next   = job.win;
                    last_next  = job.last;
                    kern_next  = {cfg.kernel_row_bottom, cfg.kernel_row_middle,
                                  cfg.kernel_row_top};
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next  = mac_sum;
                win_next  = {cpf_pkg::pix_t'(0), cpf_pkg::pix_t'(0), cpf_pkg::pix_t'(0),
                             win_reg[8:3]};
                kern_next = {cpf_pkg::kernel_row_t'(0), kern_reg[2:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == cpf_pkg::step_t'(2))
                begin
                    step_next = '0;
                    if (cfg.divisor == '0)
                    begin
                        val_next   = mac_sum;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        dvd_next   = mac_mag;
                        rem_next   = '0;
                        neg_next   = mac_sum[cpf_pkg::SUM_W-1]
                                     ^ cfg.divisor[cpf_pkg::DIV_W-1];
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                dvd_next  = quot;
                rem_next  = ge ? rem_sub[cpf_pkg::DIV_W-1:0] : rem_shift[cpf_pkg::DIV_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == cpf_pkg::step_t'(cpf_pkg::MAG_W - 1))
                begin
                    val_next   = neg_reg ? -cpf_pkg::sum_t'({1'b0, quot})
                                         : cpf_pkg::sum_t'({1'b0, quot});
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        win_reg  <= win_next;
        kern_reg <= kern_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        val_reg  <= val_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        if (load)
        begin
            result_reg.pixel_out     <= clamped;
            result_reg.last_of_frame <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 pixel filter
// Streams raster pixels and flush beats into the filter and keeps its own
// line stores, window and position. Every result beat is checked against the
// filtered value worked out for it. Kernel, divisor and offset are
// reprogrammed between phases; idling is random on both sides in the first
// two phases, and the stream runs through the opening rows of a frame.
// ----------------------------------------------------------------------------
module tb_top;

    import cpf_pkg::*;

    localparam int FRAME_PIXELS  = WIDTH * HEIGHT;
    // pixels of the frame plus the flush beats that drain the last line
    localparam int FRAME_BEATS   = FRAME_PIXELS + WIDTH + 1;
    // front end, queue, three MAC rows, clamp and bit-serial division
    localparam int SETTLE_CYCLES = 32;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [ADDR_W-3:0] FIRST_SPARE_REG = (ADDR_W-2)'(REG_COUNT);
    localparam logic [ADDR_W-3:0] LAST_SPARE_REG  = '1;

    localparam logic [23:0] ALL_MOST_NEGATIVE = 24'h808080;
    localparam logic [23:0] ALL_MOST_POSITIVE = 24'h7F7F7F;

    typedef struct packed {
        item_t beat;
        logic  drain_first;
    } stream_beat_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    item_t             item_beat    = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result_beat;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Stimulus and checking state
    stream_beat_t pending_beats [$];
    result_t      expected_pixels [$];
    int           stream_pos  = 0;
    int           gap_pct     = 0;
    int           stall_pct   = 0;
    int           fail_count  = 0;
    int           cycle_count = 0;

    // Shadow copy of the filter: configuration, line stores, window, position
    kernel_row_t             kernel_rows [3] = '{default: '0};
    logic signed [DIV_W-1:0] divisor_cfg     = '0;
    logic                    offset_cfg      = 1'b0;
    pix_t                    upper_row [WIDTH] = '{default: '0};
    pix_t                    lower_row [WIDTH] = '{default: '0};
    pix_t                    window_px [9]     = '{default: '0};
    int                      pos_col = 0;
    int                      pos_row = 0;

    conv3x3_pixel_filter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_beat),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset at the start, then release it for good
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Count the first few failures in full, the rest only in the total
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, what);
    endtask

    // Advance the shadow filter by one accepted beat. Returns 1 when the beat
    // produces a result, with the filtered pixel in res.
    function automatic bit filter_pixel(input item_t beat, output result_t res);
        int   col;
        int   row;
        int   y;
        int   x;
        int   i;
        int   j;
        int   acc;
        int   dv;
        pix_t cur;
        pix_t above2;
        pix_t above1;
        bit   hit;

        col = pos_col;
        row = pos_row;
        res = '0;

        // A flush tick inside the frame is a zero pixel; a pixel beat in the
        // flush phase is taken as a flush tick
        cur = '0;
        if (beat.operation == OP_PIXEL && row < HEIGHT)
            cur = beat.pixel_in;

        // Rotate the column through both line stores
        above2 = upper_row[col];
        above1 = lower_row[col];
        upper_row[col] = above1;
        lower_row[col] = cur;

        // Shift the window left and drop the new column in on the right
        for (i = 0; i < 3; i++)
        begin
            window_px[i * 3]     = window_px[i * 3 + 1];
            window_px[i * 3 + 1] = window_px[i * 3 + 2];
        end
        window_px[2] = above2;
        window_px[5] = above1;
        window_px[8] = cur;

        hit = (row >= 2) || (row == 1 && col >= 1);
        if (hit)
        begin
            // Output position trails the input by one line and one pixel
            if (col >= 1)
            begin
                y = row - 1;
                x = col - 1;
            end
            else
            begin
                y = row - 2;
                x = WIDTH - 1;
            end
            acc = 0;
            for (i = 0; i < 3; i++)
            begin
                if (y - 1 + i < 0 || y - 1 + i >= HEIGHT)
                    continue;
                for (j = 0; j < 3; j++)
                begin
                    // neighbours outside the frame count as zero
                    if (x - 1 + j < 0 || x - 1 + j >= WIDTH)
                        continue;
                    acc += int'(window_px[i * 3 + j]) * int'($signed(kernel_rows[i][j]));
                end
            end
            dv = int'(divisor_cfg);
            if (dv != 0)
                acc = acc / dv;
            if (offset_cfg)
                acc += OFFSET;
            if (acc > PIX_MAX)
                acc = PIX_MAX;
            if (acc < 0)
                acc = 0;
            res.pixel_out     = pix_t'(acc);
            res.last_of_frame = (y == HEIGHT - 1) && (x == WIDTH - 1);
        end

        // Wrap to a new frame once the final flush beat has gone through
        if (row == HEIGHT + 1 && col == 0)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        else
        begin
            col++;
            if (col >= WIDTH)
            begin
                col = 0;
                row++;
            end
            pos_col = col;
            pos_row = row;
        end
        return hit;
    endfunction

    // Sender: present the next pending beat, predict on acceptance. A beat
    // marked drain_first waits until every predicted pixel has come back.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        stream_beat_t queued;
        result_t      predicted;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_beat  <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (filter_pixel(item_beat, predicted))
                    expected_pixels.insert(expected_pixels.size(), predicted);
            end
            if (!item_valid || item_ready)
            begin
                if (pending_beats.size() != 0
                    && !(pending_beats[0].drain_first && expected_pixels.size() != 0)
                    && $urandom_range(0, 99) >= gap_pct)
                begin
                    queued = pending_beats.pop_front();
                    item_valid <= 1'b1;
                    item_beat  <= queued.beat;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random, compare each result beat with the oldest
    // prediction, field by field
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t wanted;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    note_failure($sformatf("unexpected result beat: pixel %0d last %0b",
                                           result_beat.pixel_out, result_beat.last_of_frame));
                end
                else
                begin
                    wanted = expected_pixels.pop_front();
                    if (result_beat.pixel_out !== wanted.pixel_out)
                        note_failure($sformatf("pixel_out: expected %0d, got %0d",
                                               wanted.pixel_out, result_beat.pixel_out));
                    if (result_beat.last_of_frame !== wanted.last_of_frame)
                        note_failure($sformatf("last_of_frame: expected %0b, got %0b",
                                               wanted.last_of_frame,
                                               result_beat.last_of_frame));
                end
            end
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: give up if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; the register lands at the
    // edge where psel and penable are both high. Mirror it in the shadow.
    task automatic write_reg(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low bits of each register are kept; spare slots drop it
        case (idx)
            REG_KERNEL_TOP:    kernel_rows[0] = value[23:0];
            REG_KERNEL_MIDDLE: kernel_rows[1] = value[23:0];
            REG_KERNEL_BOTTOM: kernel_rows[2] = value[23:0];
            REG_DIVISOR:       divisor_cfg    = value[DIV_W-1:0];
            REG_ADD_OFFSET:    offset_cfg     = value[0];
            default:           ;
        endcase
        @(negedge clk);
    endtask

    // Write all five registers, with junk in the unused upper bits
    task automatic program_filter(input logic [23:0] top_row, input logic [23:0] mid_row,
                                  input logic [23:0] bottom_row, input int div,
                                  input logic add_128);
        write_reg(REG_KERNEL_TOP,    {8'($urandom), top_row});
        write_reg(REG_KERNEL_MIDDLE, {8'($urandom), mid_row});
        write_reg(REG_KERNEL_BOTTOM, {8'($urandom), bottom_row});
        write_reg(REG_DIVISOR,       {20'($urandom), DIV_W'(div)});
        write_reg(REG_ADD_OFFSET,    {31'($urandom), add_128});
    endtask

    // Grey levels: lean on black and white so that sums hit the clamps
    function automatic pix_t pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic void push_beat(input logic op, input pix_t px, input logic drain_first);
        stream_beat_t s;
        s.beat.operation = op;
        s.beat.pixel_in  = px;
        s.drain_first    = drain_first;
        pending_beats.insert(pending_beats.size(), s);
        stream_pos = (stream_pos + 1) % FRAME_BEATS;
    endfunction

    // Well-formed stream with some noise: stray flush ticks inside the frame,
    // stray pixels in the flush phase
    function automatic void push_stream(input int count, input int noise_pct,
                                        input logic drain_first);
        int   n;
        logic op;
        for (n = 0; n < count; n++)
        begin
            if (stream_pos < FRAME_PIXELS)
                op = ($urandom_range(0, 99) < noise_pct) ? OP_FLUSH : OP_PIXEL;
            else
                op = ($urandom_range(0, 99) < noise_pct) ? OP_PIXEL : OP_FLUSH;
            push_beat(op, pick_pixel(), drain_first && n == 0);
        end
    endfunction

    // Block idle: every beat taken, every result back, back end quiet
    task automatic wait_idle();
        while (pending_beats.size() != 0 || item_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : run_test
        wait (rst_n === 1'b1);
        @(negedge clk);

        // Phase 1: sender gaps, receiver stalls hard; a divisor of 1152
        // with the offset on
        gap_pct   = 35;
        stall_pct = 87;
        program_filter(24'($urandom), 24'($urandom), 24'($urandom), 1152, 1'b1);
        // Directed opening of the frame: pixel extremes, alternating bit
        // patterns and flush ticks inside the frame
        push_beat(OP_PIXEL, 8'h00, 1'b0);
        push_beat(OP_PIXEL, 8'hFF, 1'b0);
        push_beat(OP_PIXEL, 8'h55, 1'b0);
        push_beat(OP_PIXEL, 8'hAA, 1'b0);
        push_beat(OP_PIXEL, 8'h01, 1'b0);
        push_beat(OP_PIXEL, 8'h80, 1'b0);
        push_beat(OP_PIXEL, 8'h7F, 1'b0);
        push_beat(OP_PIXEL, 8'hFE, 1'b0);
        push_beat(OP_FLUSH, 8'hFF, 1'b0);
        push_beat(OP_FLUSH, 8'h00, 1'b0);
        push_beat(OP_PIXEL, 8'hFF, 1'b0);
        push_beat(OP_PIXEL, 8'hFF, 1'b0);
        push_beat(OP_PIXEL, 8'hFF, 1'b0);
        push_stream(200, 3, 1'b0);
        // hold the sender here until the pipeline has emptied
        push_stream(150, 3, 1'b1);
        wait_idle();

        // Phase 2: sender sparse, receiver mostly ready; most negative
        // coefficients against a divisor of -1152
        gap_pct   = 87;
        stall_pct = 35;
        program_filter(ALL_MOST_NEGATIVE, ALL_MOST_NEGATIVE, ALL_MOST_NEGATIVE, -1152, 1'b0);
        push_stream(360, 3, 1'b0);
        wait_idle();

        // Phase 3: no idling from here on. No division first, so that the
        // back end goes at its full rate.
        gap_pct   = 0;
        stall_pct = 0;
        program_filter(24'($urandom), 24'($urandom), 24'($urandom), 0, 1'b1);
        push_stream(100, 3, 1'b0);
        push_stream(40, 3, 1'b1);
        wait_idle();

        // Most positive coefficients saturate; spare register slots must not
        // disturb any live register
        program_filter(ALL_MOST_POSITIVE, ALL_MOST_POSITIVE, ALL_MOST_POSITIVE, 0, 1'b0);
        write_reg(FIRST_SPARE_REG, $urandom);
        write_reg(LAST_SPARE_REG, $urandom);
        push_stream(80, 3, 1'b0);
        wait_idle();

        // Unit divisor
        program_filter(24'($urandom), 24'($urandom), 24'($urandom), 1, 1'b0);
        push_stream(80, 3, 1'b0);
        wait_idle();

        // Most negative divisor the field holds, with more flush ticks
        // inside the frame
        program_filter(ALL_MOST_POSITIVE, 24'($urandom), ALL_MOST_POSITIVE, -2048, 1'b1);
        push_stream(80, 15, 1'b0);
        wait_idle();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
